// ----- hdl/hsat_pkg.sv -----
// Shared types, constants and helpers for the Hall sensor angle and speed tracker.
`default_nettype none
package hsat_pkg;

   localparam int SectorStep      = 10923;
   localparam int TickCountWidth  = 24;
   localparam int DivNumWidth     = 32;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_CALIB = 2'd1;
   localparam logic [1:0] CMD_REINIT = 2'd2;

   localparam logic [2:0] REG_SPEED_GAIN  = 3'd0;
   localparam logic [2:0] REG_EDGE_GAIN   = 3'd1;
   localparam logic [2:0] REG_OFFSET_GAIN = 3'd2;
   localparam logic [2:0] REG_STOP_TICKS  = 3'd3;
   localparam logic [2:0] REG_CALIB_GOAL  = 3'd4;

   // Forward successor in the 1-5-4-6-2-3 chain.
   function automatic logic [2:0] succ_of(input logic [2:0] s);
      logic [2:0] r;
      case (s)
         3'd1: r = 3'd5;
         3'd2: r = 3'd3;
         3'd3: r = 3'd1;
         3'd4: r = 3'd6;
         3'd5: r = 3'd4;
         3'd6: r = 3'd2;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   // Command from controller to datapath.
   typedef struct packed {
      logic load;       // capture item, do load-time state changes
      logic edge_mul;   // form interp product
      logic edge_corr;  // form correction product
      logic edge_base;  // update base angle
      logic div_start;  // launch divider
      logic speed_mul;  // speed filter product
      logic speed_upd;  // speed filter update
      logic stop_chk;   // stop timeout
      logic adv_mul;    // advance product
      logic adv_upd;    // tracked angle update
      logic cal_mul;    // offset product
      logic cal_upd;    // offset update
   } hsat_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic is_calib;
      logic do_edge;    // legal edge with known direction
      logic resync;     // illegal jump taken
      logic div_needed; // period nonzero
      logic div_busy;
      logic cal_live;   // calibration not done
   } hsat_status_type;

endpackage
`default_nettype wire

// ----- hdl/hsat_divider.sv -----
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`default_nettype none
module hsat_divider
   import hsat_pkg::*;
#(
   parameter int NumWidth = DivNumWidth,
   parameter int DenWidth = TickCountWidth
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NumWidth-1:0] numer,
   input  wire logic [DenWidth-1:0] denom,
   output logic                     busy,
   output logic [NumWidth-1:0]      quot
);
   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] q_ff, q_in;
   logic [DenWidth:0]   rem_ff, rem_in;
   logic [DenWidth-1:0] den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [DenWidth:0]   trial;

   // One shift-subtract step per cycle
   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DenWidth-1:0], q_ff[NumWidth-1]};
      if (start) begin
         q_in    = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ----- hdl/hsat_datapath.sv -----
// Tracker state registers, arithmetic and the shared divider.
`default_nettype none
module hsat_datapath
   import hsat_pkg::*;
#(
   parameter int SectorStepP = SectorStep,
   parameter int TickWidth   = TickCountWidth
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire hsat_cmd_type    cmd,
   output hsat_status_type      status,
   input  wire logic [1:0]      req_command,
   input  wire logic [2:0]      req_hall_first,
   input  wire logic [2:0]      req_hall_second,
   input  wire logic [15:0]     req_reference_angle,
   input  wire logic [15:0]     speed_gain,
   input  wire logic [15:0]     edge_gain,
   input  wire logic [15:0]     offset_gain,
   input  wire logic [23:0]     stop_ticks,
   input  wire logic [15:0]     calib_goal,
   output logic [15:0]          electrical_angle,
   output logic signed [31:0]   reported_speed,
   output logic                 angle_valid,
   output logic                 rotor_stopped,
   output logic signed [1:0]    rotation_direction,
   output logic [2:0]           sector_code,
   output logic signed [15:0]   angle_offset,
   output logic                 offset_done
);
   localparam logic [TickWidth-1:0] TickMax = '1;
   localparam logic signed [63:0] StepClamp = 64'sd1 <<< 40;
   localparam logic signed [63:0] StepQ = 64'(SectorStepP) <<< 16;
   localparam logic [31:0] DivNum = 32'(SectorStepP) << 16;

   // Architectural state
   logic [2:0]            prev_ff, prev_in;
   logic [15:0]           base_ff, base_in;
   logic [15:0]           ang_ff, ang_in;
   logic signed [31:0]    spd_ff, spd_in;
   logic [TickWidth-1:0]  tse_ff, tse_in;
   logic [1:0]            tally_ff, tally_in;
   logic                  valid_ff, valid_in;
   logic                  stop_ff, stop_in;
   logic signed [1:0]     dir_ff, dir_in;
   logic signed [15:0]    off_ff, off_in;
   logic [15:0]           ost_ff, ost_in;
   logic                  odone_ff, odone_in;

   // Per-item work registers
   logic [1:0]            icmd_ff, icmd_in;
   logic [TickWidth-1:0]  per_ff, per_in;
   logic                  edge_ff, edge_in;
   logic                  rsy_ff, rsy_in;
   logic signed [63:0]    prod_ff, prod_in;
   logic signed [63:0]    interp_ff, interp_in;
   logic signed [31:0]    inst_ff, inst_in;
   logic signed [16:0]    diff_ff, diff_in;

   logic [2:0]            st;
   logic                  div_busy;
   logic [31:0]           quot;
   logic signed [63:0]    errv, rsum;
   logic signed [33:0]    dspd;
   logic signed [17:0]    doff;
   logic signed [49:0]    rnd50;
   logic signed [33:0]    nspd;
   logic signed [32:0]    rep;

   function automatic logic signed [63:0] rshift16(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = x + 64'sd32768;
      return y >>> 16;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   hsat_divider #(.NumWidth(32), .DenWidth(TickWidth)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (DivNum),
      .denom (per_ff),
      .busy  (div_busy),
      .quot  (quot)
   );

   assign st = (req_hall_first == req_hall_second) ? req_hall_first : 3'd0;

   always_comb begin
      prev_in = prev_ff;   base_in = base_ff;   ang_in = ang_ff;
      spd_in = spd_ff;     tse_in = tse_ff;     tally_in = tally_ff;
      valid_in = valid_ff; stop_in = stop_ff;   dir_in = dir_ff;
      off_in = off_ff;     ost_in = ost_ff;     odone_in = odone_ff;
      icmd_in = icmd_ff;   per_in = per_ff;
      edge_in = edge_ff;   rsy_in = rsy_ff;     prod_in = prod_ff;
      interp_in = interp_ff; inst_in = inst_ff; diff_in = diff_ff;
      errv = '0; rsum = '0; dspd = '0; doff = '0; rnd50 = '0; nspd = '0;

      // Capture the item and do the state changes made at load
      if (cmd.load) begin
         icmd_in = req_command;
         edge_in = 1'b0;
         rsy_in  = 1'b0;
         case (req_command)
            CMD_TICK: begin
               per_in = tse_ff;
               if (tse_ff < TickMax) begin
                  per_in = tse_ff + 1'b1;
                  tse_in = tse_ff + 1'b1;
               end
               if (st != 3'd0 && st != 3'd7) begin
                  if (prev_ff == 3'd0 || prev_ff == 3'd7) begin
                     prev_in = st;
                  end else if (st != prev_ff) begin
                     stop_in = 1'b0;
                     if (succ_of(prev_ff) == st) begin
                        dir_in = 2'sd1;  edge_in = 1'b1;
                     end else if (succ_of(st) == prev_ff) begin
                        dir_in = -2'sd1; edge_in = 1'b1;
                     end else begin
                        prev_in = st; tse_in = '0; spd_in = '0;
                        tally_in = '0; valid_in = 1'b0; rsy_in = 1'b1;
                     end
                     if (edge_in) prev_in = st;
                  end
               end
            end
            CMD_CALIB: begin
               diff_in = 17'(signed'({1'b0, req_reference_angle}) -
                              signed'({1'b0, ang_ff}));
               diff_in = {diff_in[15], diff_in[15:0]};
            end
            CMD_REINIT: begin
               prev_in = st; base_in = '0; ang_in = '0; spd_in = '0;
               tse_in = '0; tally_in = '0; valid_in = 1'b0; stop_in = 1'b0;
               dir_in = '0; off_in = '0; ost_in = '0; odone_in = 1'b0;
            end
            default: ;
         endcase
      end

      // Edge: interpolated step, clamped
      if (cmd.edge_mul) begin
         prod_in = 64'(spd_ff) * signed'({1'b0, 32'(per_ff)});
         if (prod_in > StepClamp) prod_in = StepClamp;
         if (prod_in < -StepClamp) prod_in = -StepClamp;
         interp_in = prod_in;
      end
      if (cmd.edge_corr) begin
         errv = ((dir_ff == 2'sd1) ? StepQ : -StepQ) - interp_ff;
         prod_in = 64'(signed'({1'b0, edge_gain})) * 64'(signed'(errv[42:0]));
      end
      if (cmd.edge_base) begin
         rsum = rshift16(interp_ff + rshift16(prod_ff));
         base_in = base_ff + rsum[15:0];
         tse_in = '0;
         if (tally_ff < 2'd3) tally_in = tally_ff + 1'b1;
         if (tally_ff >= 2'd1) valid_in = 1'b1;
      end

      // Speed filter after the divide
      if (cmd.speed_mul) begin
         inst_in = (dir_ff == 2'sd1) ? signed'(quot) : -signed'(quot);
         dspd = 34'(inst_in) - 34'(spd_ff);
         prod_in = 64'(signed'({1'b0, speed_gain})) * 64'(dspd);
      end
      if (cmd.speed_upd) begin
         if (tally_ff == 2'd1) spd_in = inst_ff;
         else begin
            nspd = 34'(spd_ff) + 34'(rshift16(prod_ff));
            spd_in = sat32(64'(nspd));
         end
      end

      if (cmd.stop_chk && valid_ff && 32'(tse_ff) > 32'(stop_ticks)) begin
         spd_in = '0; base_in = ang_ff; stop_in = 1'b1; dir_in = '0;
      end
      if (cmd.adv_mul)
         prod_in = 64'(spd_ff) * signed'({1'b0, 32'(tse_ff)});
      if (cmd.adv_upd && valid_ff && !stop_ff) begin
         rsum = rshift16(prod_ff);
         ang_in = base_ff + rsum[15:0];
      end

      // Offset calibration
      if (cmd.cal_mul) begin
         doff = 18'(diff_ff) - 18'(off_ff);
         rnd50 = 50'(signed'({1'b0, offset_gain})) * 50'(doff);
         prod_in = 64'(rnd50);
      end
      if (cmd.cal_upd) begin
         if (ost_ff == 16'd0) off_in = diff_ff[15:0];
         else begin
            rsum = 64'(off_ff) + rshift16(prod_ff);
            off_in = rsum[15:0];
         end
         if (ost_ff != 16'hFFFF) ost_in = ost_ff + 1'b1;
         if (ost_in >= calib_goal) odone_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;  base_ff <= '0;  ang_ff <= '0;  spd_ff <= '0;
         tse_ff <= '0;   tally_ff <= '0; valid_ff <= 1'b0; stop_ff <= 1'b0;
         dir_ff <= '0;   off_ff <= '0;   ost_ff <= '0;  odone_ff <= 1'b0;
         edge_ff <= 1'b0; rsy_ff <= 1'b0; icmd_ff <= CMD_TICK;
      end else begin
         prev_ff <= prev_in;  base_ff <= base_in;  ang_ff <= ang_in;
         spd_ff <= spd_in;    tse_ff <= tse_in;    tally_ff <= tally_in;
         valid_ff <= valid_in; stop_ff <= stop_in; dir_ff <= dir_in;
         off_ff <= off_in;    ost_ff <= ost_in;    odone_ff <= odone_in;
         edge_ff <= edge_in;  rsy_ff <= rsy_in;    icmd_ff <= icmd_in;
      end
      per_ff <= per_in; prod_ff <= prod_in;
      interp_ff <= interp_in; inst_ff <= inst_in; diff_ff <= diff_in;
   end

   assign status.is_tick    = (icmd_ff == CMD_TICK);
   assign status.is_calib   = (icmd_ff == CMD_CALIB);
   assign status.do_edge    = edge_ff;
   assign status.resync     = rsy_ff;
   assign status.div_needed = (per_ff != '0);
   assign status.div_busy   = div_busy;
   assign status.cal_live   = !odone_ff;

   // Result fields straight from state
   assign rep = valid_ff ? -33'(spd_ff) : 33'sd0;
   assign reported_speed     = sat32(64'(rep));
   assign electrical_angle   = ang_ff;
   assign angle_valid        = valid_ff;
   assign rotor_stopped      = stop_ff;
   assign rotation_direction = dir_ff;
   assign sector_code        = prev_ff;
   assign angle_offset       = off_ff;
   assign offset_done        = odone_ff;
endmodule
`default_nettype wire

// ----- hdl/hsat_controller.sv -----
// Sequencer that steps the datapath through one item.
`default_nettype none
module hsat_controller
   import hsat_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire hsat_status_type status,
   output hsat_cmd_type       cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_EMUL, S_ECORR, S_EBASE, S_DIVGO, S_DIVWAIT,
      S_SMUL, S_SUPD, S_STOP, S_AMUL, S_AUPD, S_CMUL, S_CUPD, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_ff, rsp_in;
   logic      fire;

   // Result waits in rsp; a new item may enter only once rsp is clear or being taken
   assign fire = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      rsp_in = rsp_ff;
      cmd = '0;
      if (rsp_ff && rsp_ready) rsp_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (fire) begin cmd.load = 1'b1; state_in = S_DECODE; end
         S_DECODE: begin
            if (status.is_tick) begin
               if (status.resync) state_in = S_DONE;
               else if (status.do_edge) state_in = S_EMUL;
               else state_in = S_STOP;
            end else if (status.is_calib && status.cal_live) state_in = S_CMUL;
            else state_in = S_DONE;
         end
         S_EMUL:  begin cmd.edge_mul = 1'b1;  state_in = S_ECORR; end
         S_ECORR: begin cmd.edge_corr = 1'b1; state_in = S_EBASE; end
         S_EBASE: begin
            cmd.edge_base = 1'b1;
            state_in = status.div_needed ? S_DIVGO : S_STOP;
         end
         S_DIVGO: begin cmd.div_start = 1'b1; state_in = S_DIVWAIT; end
         S_DIVWAIT: if (!status.div_busy) state_in = S_SMUL;
         S_SMUL: begin cmd.speed_mul = 1'b1; state_in = S_SUPD; end
         S_SUPD: begin cmd.speed_upd = 1'b1; state_in = S_STOP; end
         S_STOP: begin cmd.stop_chk = 1'b1;  state_in = S_AMUL; end
         S_AMUL: begin cmd.adv_mul = 1'b1;   state_in = S_AUPD; end
         S_AUPD: begin cmd.adv_upd = 1'b1;   state_in = S_DONE; end
         S_CMUL: begin cmd.cal_mul = 1'b1;   state_in = S_CUPD; end
         S_CUPD: begin cmd.cal_upd = 1'b1;   state_in = S_DONE; end
         S_DONE: if (!rsp_in) begin rsp_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_ff;
endmodule
`default_nettype wire

// ----- hdl/hall_sensor_angle_speed_tracker_top.sv -----
// Top level of the Hall sensor angle and speed tracker.
// One item at a time. A tick without a Hall edge runs the stop check and advance; a
// tick with an edge first updates the base angle and, if the period is nonzero,
// waits on the 32-step bit-serial divider and filters speed. A calibration sample
// runs the offset update; reinitialize, a calibration sample after calibration is
// done, or the unused command go straight to the result. Result fields reflect
// state after the item and hold while the result transfer waits; the next item is
// taken no earlier than the cycle after that transfer, since results read live
// state. Registers sit on a small APB port at 4*index; write them only while idle.
`default_nettype none
module hall_sensor_angle_speed_tracker_top
   import hsat_pkg::*;
#(
   parameter int SectorStepP = SectorStep,
   parameter int TickWidth   = TickCountWidth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [2:0]  req_hall_first,
   input  wire logic [2:0]  req_hall_second,
   input  wire logic [15:0] req_reference_angle,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_electrical_angle,
   output logic signed [31:0] rsp_reported_speed,
   output logic             rsp_angle_valid,
   output logic             rsp_rotor_stopped,
   output logic signed [1:0] rsp_rotation_direction,
   output logic [2:0]       rsp_sector_code,
   output logic signed [15:0] rsp_angle_offset,
   output logic             rsp_offset_done,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   hsat_cmd_type    cmd;
   hsat_status_type status;
   logic            rdy;

   logic [15:0] sg_ff, eg_ff, og_ff, cg_ff;
   logic [23:0] st_ff;
   logic [2:0]  ridx;

   // Register file
   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[4:2];
   always_ff @(posedge clock) begin
      if (reset) begin
         sg_ff <= 16'd13107; eg_ff <= 16'd9830; og_ff <= 16'd328;
         st_ff <= 24'd10000; cg_ff <= 16'd2000;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[1:0] == 2'b00) begin
         unique case (ridx)
            REG_SPEED_GAIN:  sg_ff <= csr_pwdata[15:0];
            REG_EDGE_GAIN:   eg_ff <= csr_pwdata[15:0];
            REG_OFFSET_GAIN: og_ff <= csr_pwdata[15:0];
            REG_STOP_TICKS:  st_ff <= csr_pwdata[23:0];
            REG_CALIB_GOAL:  cg_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         REG_SPEED_GAIN:  csr_prdata = {16'd0, sg_ff};
         REG_EDGE_GAIN:   csr_prdata = {16'd0, eg_ff};
         REG_OFFSET_GAIN: csr_prdata = {16'd0, og_ff};
         REG_STOP_TICKS:  csr_prdata = {8'd0, st_ff};
         REG_CALIB_GOAL:  csr_prdata = {16'd0, cg_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Hold off input while a result is pending so outputs stay stable
   assign req_ready = rdy && !rsp_valid;

   hsat_controller u_ctrl (
      .clock (clock), .reset (reset),
      .req_valid (req_valid && !rsp_valid), .req_ready (rdy),
      .rsp_valid (rsp_valid), .rsp_ready (rsp_ready),
      .status (status), .cmd (cmd)
   );

   hsat_datapath #(.SectorStepP(SectorStepP), .TickWidth(TickWidth)) u_dp (
      .clock (clock), .reset (reset), .cmd (cmd), .status (status),
      .req_command (req_command), .req_hall_first (req_hall_first),
      .req_hall_second (req_hall_second), .req_reference_angle (req_reference_angle),
      .speed_gain (sg_ff), .edge_gain (eg_ff), .offset_gain (og_ff),
      .stop_ticks (st_ff), .calib_goal (cg_ff),
      .electrical_angle (rsp_electrical_angle), .reported_speed (rsp_reported_speed),
      .angle_valid (rsp_angle_valid), .rotor_stopped (rsp_rotor_stopped),
      .rotation_direction (rsp_rotation_direction), .sector_code (rsp_sector_code),
      .angle_offset (rsp_angle_offset), .offset_done (rsp_offset_done)
   );
endmodule
`default_nettype wire
